// ----- hw/rtl/binary_kv_sasl_erlang_classifier_macros.svh -----
// assertion helpers for the classifier
`ifndef BINARY_KV_SASL_ERLANG_CLASSIFIER_MACROS_SVH
`define BINARY_KV_SASL_ERLANG_CLASSIFIER_MACROS_SVH
`define BKC_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BKC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hw/rtl/bkc_pkg.sv -----
//------------------------------------------------------------------------------
// bkc_pkg
// types and constants shared by the classifier modules
//------------------------------------------------------------------------------
`default_nettype none
package bkc_pkg;
	localparam int unsigned MAX_PAYLOAD_DEF = 65535;
	localparam int unsigned HDR_N = 24;
	localparam int unsigned WIN_N = 12;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [2:0] {
		V_CONT = 3'd0, V_WAIT = 3'd1, V_REJECT = 3'd2, V_IDENT = 3'd3, V_DONE = 3'd4
	} verdict_t;
	typedef enum logic [1:0] {
		K_NONE = 2'd0, K_KV = 2'd1, K_PMAP = 2'd2, K_DIST = 2'd3
	} kind_t;
	typedef enum logic [1:0] {
		PM_NONE = 2'd0, PM_Z = 2'd1, PM_X = 2'd2
	} pmap_t;
	typedef enum logic [1:0] {
		CFG_FRAME = 2'd0, CFG_VER = 2'd1, CFG_BODY = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] MARK_NONE = 2'd0;
	localparam logic [1:0] MARK_SERVER = 2'd1;
	localparam logic [1:0] MARK_CLIENT = 2'd2;

	localparam logic [7:0] KV_REQ_MAGIC = 8'h80;
	localparam logic [7:0] KV_RSP_MAGIC = 8'h81;
	localparam logic [7:0] OP_LIST = 8'h20;
	localparam logic [7:0] OP_AUTH = 8'h21;

	typedef struct packed {
		logic [15:0] frame_max;
		logic [15:0] ver_max;
		logic [15:0] body_max;
	} cfg_t;

	// session state
	typedef struct packed {
		logic  open;
		logic  decided;
		logic  saw_req;
		logic  op_auth;
		logic  pm_seen;
		pmap_t pm_code;
		logic  dreq;
		logic  dresp;
	} sess_t;

	// a finished packet handed from the byte stage to the verdict stage
	typedef struct packed {
		logic [HDR_N-1:0][7:0] hdr;
		logic [15:0]           len;
		logic                  mech;
		logic                  client;
		logic                  ingress;
		logic                  sbegin;
	} pkt_t;

	typedef struct packed {
		verdict_t   verdict;
		kind_t      kind;
		logic [1:0] mark;
	} res_t;

	function automatic logic node_ok(input logic [7:0] t);
		return t == 8'd72 || t == 8'd77 || t == 8'd104 || t == 8'd109 || t == 8'd110;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bkc_if.sv -----
//------------------------------------------------------------------------------
// bkc_in_if, bkc_out_if, bkc_cfg_if
// valid/ready channels of the classifier
//------------------------------------------------------------------------------
`default_nettype none
interface bkc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       from_client;
	logic       packet_first;
	logic       packet_last;
	logic       session_begin;
	logic       session_ingress;
	modport source (output valid, payload_byte, from_client, packet_first, packet_last,
		session_begin, session_ingress, input ready);
	modport sink (input valid, payload_byte, from_client, packet_first, packet_last,
		session_begin, session_ingress, output ready);
endinterface

interface bkc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [1:0] matched_kind;
	logic [1:0] endpoint_mark;
	modport source (output valid, verdict, matched_kind, endpoint_mark, input ready);
	modport sink (input valid, verdict, matched_kind, endpoint_mark, output ready);
endinterface

interface bkc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bkc_capture.sv -----
//------------------------------------------------------------------------------
// bkc_capture
// per-byte stage: header store, byte count and mechanism name match
//------------------------------------------------------------------------------
`default_nettype none
module bkc_capture
	import bkc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] byte_in,
	input  wire logic       client,
	input  wire logic       first,
	input  wire logic       sbegin,
	input  wire logic       ingress,
	output pkt_t            pkt
);
	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned KW = CW + 18;

	logic [HDR_N-1:0][7:0] hdr_q;
	logic [WIN_N-1:0][7:0] win_q;
	logic [CW-1:0]         cnt_q;
	logic                  mech_q;
	logic                  client_q;

	logic                  st;
	logic [HDR_N-1:0][7:0] hdr_n;
	logic [WIN_N-1:0][7:0] win_n;
	logic [CW-1:0]         pos;
	logic [KW-1:0]         posw;
	logic                  mech_n;
	logic                  cl_n;
	logic                  hit;
	logic                  in_region;
	logic [KW-1:0]         key_end;
	logic [CW-1:0]         len_n;

	// window index 11 holds the newest byte
	function automatic logic tail_is(input logic [WIN_N-1:0][7:0] w,
		input logic [8*WIN_N-1:0] s, input int unsigned n);
		logic r;
		r = 1'b1;
		for (int j = 0; j < WIN_N; j++)
			if (j < n && w[WIN_N-n+j] != s[8*(n-1-j) +: 8]) r = 1'b0;
		return r;
	endfunction

	always_comb begin
		st = first | sbegin;
		cl_n = st ? client : client_q;
		pos = st ? '0 : cnt_q;
		posw = KW'(pos);
		hdr_n = st ? '0 : hdr_q;
		win_n = st ? '0 : win_q;
		mech_n = st ? 1'b0 : mech_q;
		for (int i = 0; i < HDR_N; i++)
			if (pos == CW'(i)) hdr_n[i] = byte_in;
		for (int i = 0; i < WIN_N-1; i++)
			win_n[i] = win_n[i+1];
		win_n[WIN_N-1] = byte_in;
		key_end = KW'(24) + KW'({hdr_n[2], hdr_n[3]});
		in_region = !cl_n || (posw < key_end);
		hit = 1'b0;
		if (posw >= KW'(28) && tail_is(win_n, {56'd0, "PLAIN"}, 5)) hit = 1'b1;
		if (posw >= KW'(31) && tail_is(win_n, {32'd0, "CRAM-MD5"}, 8)) hit = 1'b1;
		if (posw >= KW'(33) && tail_is(win_n, {16'd0, "SCRAM-SHA1"}, 10)) hit = 1'b1;
		if (posw >= KW'(35) && tail_is(win_n, "SCRAM-SHA256", 12)) hit = 1'b1;
		if (posw >= KW'(35) && tail_is(win_n, "SCRAM-SHA512", 12)) hit = 1'b1;
		if (posw >= KW'(24) && in_region && hit) mech_n = 1'b1;
		if (pos < CW'(MAX_PAYLOAD)) len_n = pos + CW'(1);
		else len_n = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mech_q <= 1'b0;
			client_q <= 1'b0;
			hdr_q <= '0;
			win_q <= '0;
		end else if (take) begin
			cnt_q <= len_n;
			mech_q <= mech_n;
			client_q <= cl_n;
			hdr_q <= hdr_n;
			win_q <= win_n;
		end
	end

	// the verdict logic only compares against small lengths
	always_comb begin
		pkt.hdr = hdr_n;
		if (KW'(len_n) > KW'(16'hffff)) pkt.len = 16'hffff;
		else pkt.len = 16'(len_n);
		pkt.mech = mech_n;
		pkt.client = cl_n;
		pkt.ingress = ingress;
		pkt.sbegin = sbegin;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bkc_decide.sv -----
//------------------------------------------------------------------------------
// bkc_decide
// verdict logic for one finished packet and next session state
//------------------------------------------------------------------------------
`default_nettype none
module bkc_decide
	import bkc_pkg::*;
(
	input  wire pkt_t  pkt,
	input  wire sess_t sess,
	input  wire cfg_t  cfg,
	output res_t       res,
	output sess_t      sess_n
);
	localparam logic [8*11-1:0] ST_REFUSED = {"not_", "allowed"};

	logic [1:0]  dres;
	logic [15:0] len;
	logic [7:0]  magic;
	logic [7:0]  op;
	logic        zero_req;
	logic        zero_rsp;
	logic [31:0] body;
	logic        ok;
	logic        both;
	logic [1:0]  mk;
	sess_t       s;

	function automatic logic hdr_eq(input logic [HDR_N-1:0][7:0] h,
		input logic [8*11-1:0] str, input int unsigned n);
		logic r;
		r = 1'b1;
		for (int i = 0; i < 11; i++)
			if (i < n && h[3+i] != str[8*(n-1-i) +: 8]) r = 1'b0;
		return r;
	endfunction

	always_comb begin
		len = pkt.len;
		dres = 2'd1;
		if (len < 16'd5 || {pkt.hdr[0], pkt.hdr[1]} > cfg.frame_max) dres = 2'd0;
		else if (pkt.hdr[2] == "n") begin
			if ({pkt.hdr[3], pkt.hdr[4]} > cfg.ver_max) dres = 2'd0;
		end else if (pkt.hdr[2] == "s") begin
			if (hdr_eq(pkt.hdr, {72'd0, "ok"}, 2) ||
				(len >= 16'd6 && hdr_eq(pkt.hdr, {64'd0, "nok"}, 3)) ||
				(len >= 16'd14 && hdr_eq(pkt.hdr, ST_REFUSED, 11)) ||
				(len >= 16'd8 && hdr_eq(pkt.hdr, {48'd0, "alive"}, 5)))
				dres = 2'd2;
		end else if (pkt.hdr[2] != "r" && pkt.hdr[2] != "a") dres = 2'd0;
	end

	always_comb begin
		magic = pkt.hdr[0];
		op = pkt.hdr[1];
		zero_req = 1'b1;
		zero_rsp = 1'b1;
		for (int i = 2; i < HDR_N; i++) begin
			if (pkt.hdr[i] != 8'd0) zero_rsp = 1'b0;
			if ((i < 12 || i > 15) && pkt.hdr[i] != 8'd0) zero_req = 1'b0;
		end
		body = {pkt.hdr[8], pkt.hdr[9], pkt.hdr[10], pkt.hdr[11]};
		mk = pkt.ingress ? MARK_SERVER : MARK_CLIENT;
		s = sess;
		if (pkt.sbegin) s = '0;
		res = '{verdict: V_WAIT, kind: K_NONE, mark: MARK_NONE};
		ok = 1'b0;
		both = s.dreq && s.dresp;
		if (s.decided) res.verdict = V_DONE;
		else if (!s.open && !pkt.client) begin
			s.decided = 1'b1;
			res.verdict = V_REJECT;
		end else begin
			s.open = 1'b1;
			if (len < 16'd4) res.verdict = V_WAIT;
			else if (pkt.client) begin
				if (pkt.hdr[2] == "z") begin
					s.pm_code = PM_Z; s.pm_seen = 1'b1;
					res = '{verdict: V_CONT, kind: K_PMAP, mark: MARK_NONE};
				end else if (pkt.hdr[2] == "x" && len >= 16'd12 && node_ok(pkt.hdr[5])
					&& pkt.hdr[6] == 8'd0) begin
					s.pm_code = PM_X; s.pm_seen = 1'b1;
					res = '{verdict: V_CONT, kind: K_PMAP, mark: MARK_NONE};
				end else if (dres != 2'd0) begin
					s.dreq = 1'b1;
					res.kind = K_DIST;
					res.verdict = V_CONT;
					if (both) begin s.decided = 1'b1; res.verdict = V_IDENT; end
				end else if (magic != KV_REQ_MAGIC || pkt.hdr[5] > 8'd3) begin
					s.decided = 1'b1; res.verdict = V_REJECT;
				end else if (op == OP_LIST) begin
					if (len < 16'd24) res.verdict = V_WAIT;
					else if (!zero_req) begin s.decided = 1'b1; res.verdict = V_REJECT; end
					else begin
						s.op_auth = 1'b0; s.saw_req = 1'b1;
						res = '{verdict: V_CONT, kind: K_KV, mark: MARK_NONE};
					end
				end else if (op == OP_AUTH) begin
					if (len < 16'd29) res.verdict = V_WAIT;
					else if (!pkt.mech) begin s.decided = 1'b1; res.verdict = V_REJECT; end
					else begin
						s.op_auth = 1'b1; s.saw_req = 1'b1;
						res = '{verdict: V_CONT, kind: K_KV, mark: MARK_NONE};
					end
				end else begin
					s.decided = 1'b1; res.verdict = V_REJECT;
				end
			end else if (s.pm_seen) begin
				if (magic == "w")
					ok = s.pm_code == PM_Z && len >= 16'd12 && node_ok(pkt.hdr[4])
						&& pkt.hdr[5] == 8'd0;
				else if (magic == "y") ok = s.pm_code == PM_X;
				s.decided = 1'b1;
				if (ok) res = '{verdict: V_IDENT, kind: K_PMAP, mark: mk};
				else res.verdict = V_REJECT;
			end else if (s.dreq) begin
				if (dres == 2'd0) begin s.decided = 1'b1; res.verdict = V_REJECT; end
				else begin
					res.kind = K_DIST;
					if (dres == 2'd2 || s.dresp) begin
						s.decided = 1'b1; res.verdict = V_IDENT;
					end else res.verdict = V_CONT;
					s.dresp = 1'b1;
				end
			end else if (magic != KV_RSP_MAGIC) begin
				s.decided = 1'b1; res.verdict = V_REJECT;
			end else if (op == OP_LIST) begin
				if (!s.saw_req || s.op_auth) begin s.decided = 1'b1; res.verdict = V_REJECT; end
				else if (len < 16'd29) res.verdict = V_WAIT;
				else begin
					s.decided = 1'b1;
					if (body < 32'd5 || body > {16'd0, cfg.body_max} || !pkt.mech)
						res.verdict = V_REJECT;
					else res = '{verdict: V_IDENT, kind: K_KV, mark: mk};
				end
			end else if (op == OP_AUTH) begin
				if (!s.saw_req || !s.op_auth) begin s.decided = 1'b1; res.verdict = V_REJECT; end
				else if (len < 16'd24) res.verdict = V_WAIT;
				else begin
					s.decided = 1'b1;
					if (!zero_rsp) res.verdict = V_REJECT;
					else res = '{verdict: V_IDENT, kind: K_KV, mark: mk};
				end
			end else begin
				s.decided = 1'b1; res.verdict = V_REJECT;
			end
		end
		sess_n = s;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/binary_kv_sasl_erlang_classifier.sv -----
//------------------------------------------------------------------------------
// binary_kv_sasl_erlang_classifier
// per-session key-value SASL / Erlang handshake classifier
//------------------------------------------------------------------------------
// usage:
//   in: one payload byte per word with direction, packet and session marks
//   out: one verdict word for every byte marked packet_last
//   cfg: register writes (index 0 frame max, 1 version max, 2 body max),
//        only while the block is idle
// result: a verdict is loaded into the output register when the last byte of a
//   packet is accepted
// throughput: one byte per cycle while ready is high; the per-byte header, count and
//   window update and the verdict logic are combinational
// stall: ready stays high while the output register is empty or being read;
//   if a verdict is waiting and not taken, input is held off
// reset: session and packet state clear, registers return to 256, 16, 256;
//   the output register is empty
//------------------------------------------------------------------------------
`default_nettype none
`include "binary_kv_sasl_erlang_classifier_macros.svh"
module binary_kv_sasl_erlang_classifier
	import bkc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bkc_in_if.sink   in_ch,
	bkc_out_if.source out_ch,
	bkc_cfg_if.sink  cfg_ch
);
	cfg_t  cfg_q;
	sess_t sess_q;
	sess_t sess_n;
	pkt_t  pkt;
	res_t  res;
	res_t  res_q;
	logic  ovalid_q;
	logic  take;

	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	bkc_capture #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_cap (
		.clk(clk), .arst_n(arst_n), .take(take), .byte_in(in_ch.payload_byte),
		.client(in_ch.from_client), .first(in_ch.packet_first),
		.sbegin(in_ch.session_begin), .ingress(in_ch.session_ingress), .pkt(pkt)
	);

	bkc_decide u_dec (.pkt(pkt), .sess(sess_q), .cfg(cfg_q), .res(res), .sess_n(sess_n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{frame_max: 16'd256, ver_max: 16'd16, body_max: 16'd256};
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				CFG_FRAME: cfg_q.frame_max <= cfg_ch.data;
				CFG_VER:   cfg_q.ver_max <= cfg_ch.data;
				CFG_BODY:  cfg_q.body_max <= cfg_ch.data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				if (in_ch.packet_last) sess_q <= sess_n;
				else if (in_ch.session_begin) sess_q <= '0;
			end
			if (take && in_ch.packet_last) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_ch.packet_last) res_q <= res;
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.verdict = res_q.verdict;
	assign out_ch.matched_kind = res_q.kind;
	assign out_ch.endpoint_mark = res_q.mark;

	`BKC_ASSERT_NEXT(a_result_loaded, clk, arst_n, take && in_ch.packet_last, out_ch.valid)
	`BKC_ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.verdict))
	`BKC_ASSERT_IMP(a_done_no_kind, clk, arst_n,
		out_ch.valid && out_ch.verdict == V_DONE, out_ch.matched_kind == K_NONE)
endmodule
`default_nettype wire

// ----- test/binary_kv_sasl_erlang_classifier_checker.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// binary_kv_sasl_erlang_classifier_checker
// Watches the byte, verdict and register channels of the classifier. It keeps
// its own copy of the session, packet and register state and works out the
// verdict for every last byte. Each verdict word leaving the block is compared
// field by field with the oldest verdict still owed.
//------------------------------------------------------------------------------
`default_nettype none
module binary_kv_sasl_erlang_classifier_checker
	import bkc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	bkc_in_if        in_ch,
	bkc_out_if       out_ch,
	bkc_cfg_if       cfg_ch,
	output int       fail_count,
	output int       owed_count,
	output int       verdict_count,
	output int       ident_count,
	output int       reject_count
);
	localparam int unsigned SAT_LEN = MAX_PAYLOAD_DEF;

	string mech_names [5] = '{"PLAIN", "CRAM-MD5", "SCRAM-SHA1", "SCRAM-SHA256",
		"SCRAM-SHA512"};
	string st_refused = {"not_", "allowed"};

	res_t owed_verdicts [$];

	logic [15:0] frame_max, ver_max, body_max;
	bit          s_open, s_decided, s_saw_req, s_op_auth, s_pm_seen, s_dreq, s_dresp;
	pmap_t       s_pm_code;
	bit          p_mech, p_client;
	logic [7:0]  hdr [HDR_N];
	logic [7:0]  win [WIN_N];
	int unsigned byte_cnt;

	function automatic bit node_name_ok(logic [7:0] t);
		return t == 8'd72 || t == 8'd77 || t == 8'd104 || t == 8'd109 || t == 8'd110;
	endfunction

	function automatic bit hdr_text(int at, string s);
		for (int i = 0; i < s.len(); i++)
			if (hdr[at + i] != s[i]) return 0;
		return 1;
	endfunction

	// 0 not a distribution message, 1 handshake message, 2 final status
	function automatic int dist_kind(int unsigned len);
		int unsigned frame, ver, left;
		logic [7:0]  tag;
		if (len < 5) return 0;
		frame = {hdr[0], hdr[1]};
		tag = hdr[2];
		if (frame > frame_max) return 0;
		if (tag != "n" && tag != "r" && tag != "a" && tag != "s") return 0;
		if (tag == "n") begin
			ver = {hdr[3], hdr[4]};
			return (ver > ver_max) ? 0 : 1;
		end
		if (tag == "s") begin
			left = len - 3;
			if (hdr_text(3, "ok") || (left >= 3 && hdr_text(3, "nok")) ||
					(left >= 11 && hdr_text(3, st_refused)) ||
					(left >= 5 && hdr_text(3, "alive")))
				return 2;
		end
		return 1;
	endfunction

	function automatic res_t classify(bit ingress);
		res_t        r;
		int unsigned len, body;
		int          dk;
		bit          both;
		len = byte_cnt;
		r.verdict = V_REJECT;
		r.kind = K_NONE;
		r.mark = MARK_NONE;
		if (s_decided) begin
			r.verdict = V_DONE;
			return r;
		end
		if (!s_open) begin
			if (!p_client) begin
				s_decided = 1;
				return r;
			end
			s_open = 1;
		end
		r.verdict = V_WAIT;
		if (len < 4) return r;
		if (p_client) begin
			if (hdr[2] == "z" || (hdr[2] == "x" && len >= 12 && node_name_ok(hdr[5]) &&
					hdr[6] == 8'd0)) begin
				s_pm_code = (hdr[2] == "z") ? PM_Z : PM_X;
				s_pm_seen = 1;
				r.kind = K_PMAP;
				r.verdict = V_CONT;
				return r;
			end
			if (dist_kind(len) != 0) begin
				both = s_dreq && s_dresp;
				s_dreq = 1;
				r.kind = K_DIST;
				r.verdict = both ? V_IDENT : V_CONT;
				if (both) s_decided = 1;
				return r;
			end
			r.verdict = V_REJECT;
			if (hdr[0] != KV_REQ_MAGIC || hdr[5] > 8'd3) begin
				s_decided = 1;
				return r;
			end
			if (hdr[1] == OP_LIST) begin
				if (len < 24) begin
					r.verdict = V_WAIT;
					return r;
				end
				for (int i = 2; i < 24; i++)
					if ((i < 12 || i > 15) && hdr[i] != 8'd0) begin
						s_decided = 1;
						return r;
					end
			end else if (hdr[1] == OP_AUTH) begin
				if (len < 29) begin
					r.verdict = V_WAIT;
					return r;
				end
				if (!p_mech) begin
					s_decided = 1;
					return r;
				end
			end else begin
				s_decided = 1;
				return r;
			end
			s_op_auth = (hdr[1] == OP_AUTH);
			s_saw_req = 1;
			r.kind = K_KV;
			r.verdict = V_CONT;
			return r;
		end
		r.verdict = V_REJECT;
		if (s_pm_seen) begin
			s_decided = 1;
			if ((hdr[0] == "w" && s_pm_code == PM_Z && len >= 12 && node_name_ok(hdr[4]) &&
					hdr[5] == 8'd0) || (hdr[0] == "y" && s_pm_code == PM_X)) begin
				r.verdict = V_IDENT;
				r.kind = K_PMAP;
				r.mark = ingress ? MARK_SERVER : MARK_CLIENT;
			end
			return r;
		end
		if (s_dreq) begin
			dk = dist_kind(len);
			if (dk == 0) begin
				s_decided = 1;
				return r;
			end
			r.kind = K_DIST;
			r.verdict = (dk == 2 || s_dresp) ? V_IDENT : V_CONT;
			if (r.verdict == V_IDENT) s_decided = 1;
			s_dresp = 1;
			return r;
		end
		if (hdr[0] != KV_RSP_MAGIC) begin
			s_decided = 1;
			return r;
		end
		if (hdr[1] == OP_LIST) begin
			if (!s_saw_req || s_op_auth) begin
				s_decided = 1;
				return r;
			end
			if (len < 29) begin
				r.verdict = V_WAIT;
				return r;
			end
			body = {hdr[8], hdr[9], hdr[10], hdr[11]};
			if (body < 5 || body > body_max || !p_mech) begin
				s_decided = 1;
				return r;
			end
		end else if (hdr[1] == OP_AUTH) begin
			if (!s_saw_req || !s_op_auth) begin
				s_decided = 1;
				return r;
			end
			if (len < 24) begin
				r.verdict = V_WAIT;
				return r;
			end
			for (int i = 2; i < 24; i++)
				if (hdr[i] != 8'd0) begin
					s_decided = 1;
					return r;
				end
		end else begin
			s_decided = 1;
			return r;
		end
		s_decided = 1;
		r.verdict = V_IDENT;
		r.kind = K_KV;
		r.mark = ingress ? MARK_SERVER : MARK_CLIENT;
		return r;
	endfunction

	function automatic void clear_session();
		{s_open, s_decided, s_saw_req, s_op_auth, s_pm_seen, s_dreq, s_dresp} = '0;
		s_pm_code = PM_NONE;
	endfunction

	function automatic void open_packet(bit fc);
		foreach (hdr[i]) hdr[i] = 8'd0;
		foreach (win[i]) win[i] = 8'd0;
		byte_cnt = 0;
		p_mech = 0;
		p_client = fc;
	endfunction

	function automatic void take_byte(logic [7:0] b, bit fc, bit first, bit last, bit sb,
			bit ingress);
		int unsigned pos, key_len, n;
		bit          eq;
		if (sb) begin
			clear_session();
			first = 1;
		end
		if (first) open_packet(fc);
		pos = byte_cnt;
		if (pos < HDR_N) hdr[pos] = b;
		for (int i = 0; i < WIN_N - 1; i++) win[i] = win[i + 1];
		win[WIN_N - 1] = b;
		if (pos >= 24) begin
			key_len = {hdr[2], hdr[3]};
			if (!p_client || pos < 24 + key_len)
				foreach (mech_names[k]) begin
					n = mech_names[k].len();
					eq = pos >= 23 + n;
					for (int j = 0; j < n && eq; j++)
						if (win[WIN_N - n + j] != mech_names[k][j]) eq = 0;
					if (eq) p_mech = 1;
				end
		end
		if (byte_cnt < SAT_LEN) byte_cnt++;
		if (last) owed_verdicts.push_back(classify(ingress));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			frame_max <= 16'd256;
			ver_max <= 16'd16;
			body_max <= 16'd256;
			clear_session();
			open_packet(0);
			owed_verdicts.delete();
			fail_count <= 0;
			owed_count <= 0;
			verdict_count <= 0;
			ident_count <= 0;
			reject_count <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				case (cfg_idx_t'(cfg_ch.index))
					CFG_FRAME: frame_max <= cfg_ch.data;
					CFG_VER: ver_max <= cfg_ch.data;
					CFG_BODY: body_max <= cfg_ch.data;
					default: ;
				endcase
			if (in_ch.valid && in_ch.ready)
				take_byte(in_ch.payload_byte, in_ch.from_client, in_ch.packet_first,
					in_ch.packet_last, in_ch.session_begin, in_ch.session_ingress);
			if (out_ch.valid && out_ch.ready) begin
				verdict_count <= verdict_count + 1;
				if (owed_verdicts.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: verdict word with none owed: %0d %0d %0d", $realtime,
							out_ch.verdict, out_ch.matched_kind, out_ch.endpoint_mark);
					fail_count <= fail_count + 1;
				end else begin
					want = owed_verdicts.pop_front();
					if (want.verdict == V_IDENT) ident_count <= ident_count + 1;
					if (want.verdict == V_REJECT) reject_count <= reject_count + 1;
					if (out_ch.verdict !== want.verdict || out_ch.matched_kind !== want.kind ||
							out_ch.endpoint_mark !== want.mark) begin
						if (fail_count < 10)
							$display("%0t: verdict/kind/mark expected %0d %0d %0d got %0d %0d %0d",
								$realtime, want.verdict, want.kind, want.mark, out_ch.verdict,
								out_ch.matched_kind, out_ch.endpoint_mark);
						fail_count <= fail_count + 1;
					end
				end
			end
			owed_count <= owed_verdicts.size();
		end
	end
endmodule
`default_nettype wire

// ----- test/binary_kv_sasl_erlang_classifier_test.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// binary_kv_sasl_erlang_classifier_test
// Drives whole sessions of key-value SASL, port-mapper and distribution
// handshakes, broken and noisy traffic and register changes into the
// classifier, with random gaps and stalls; a checker beside the block
// predicts and compares every verdict.
//------------------------------------------------------------------------------
`default_nettype none
module binary_kv_sasl_erlang_classifier_test;
	import bkc_pkg::*;

	typedef logic [7:0] byte_q_t [$];

	localparam int STALL_LIMIT = 40000;

	string mech_names [5] = '{"PLAIN", "CRAM-MD5", "SCRAM-SHA1", "SCRAM-SHA256",
		"SCRAM-SHA512"};

	logic clk;
	logic arst_n;
	bkc_in_if  in_ch ();
	bkc_out_if out_ch ();
	bkc_cfg_if cfg_ch ();

	int fail_count, owed_count, verdict_count, ident_count, reject_count;
	int idle_cycles;
	int random_pkts;
	bit no_gaps;
	bit hold_req;

	binary_kv_sasl_erlang_classifier dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	binary_kv_sasl_erlang_classifier_checker verdict_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
		.fail_count(fail_count), .owed_count(owed_count), .verdict_count(verdict_count),
		.ident_count(ident_count), .reject_count(reject_count)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 0;
				stall = 300;
				while (stall > 0) begin
					@(posedge clk);
					stall--;
				end
				hold_req = 0;
				out_ch.ready <= 1;
			end else if (!out_ch.ready) begin
				out_ch.ready <= 1;
			end else begin
				stall = gap_len();
				if (stall > 0) begin
					out_ch.ready <= 0;
					repeat (stall - 1) @(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic put_byte(logic [7:0] b, bit fc, bit first, bit last, bit sb, bit ingress);
		int g;
		in_ch.valid <= 1;
		in_ch.payload_byte <= b;
		in_ch.from_client <= fc;
		in_ch.packet_first <= first;
		in_ch.packet_last <= last;
		in_ch.session_begin <= sb;
		in_ch.session_ingress <= ingress;
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic put_packet(byte_q_t q, bit fc, bit sb, bit ingress, bit no_first = 0);
		foreach (q[i])
			put_byte(q[i], fc, i == 0 && !no_first, i == q.size() - 1, i == 0 && sb, ingress);
	endtask

	// valid stays up between back to back writes; the caller drops it
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(negedge clk);
		while (!cfg_ch.ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic byte_q_t zeros(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'd0);
		return q;
	endfunction

	function automatic byte_q_t rand_bytes(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	function automatic logic [7:0] node_byte();
		logic [7:0] nodes [5] = '{8'd72, 8'd77, 8'd104, 8'd109, 8'd110};
		return nodes[$urandom_range(0, 4)];
	endfunction

	function automatic byte_q_t kv_list_req();
		byte_q_t q = zeros(24);
		q[0] = KV_REQ_MAGIC;
		q[1] = OP_LIST;
		for (int i = 12; i < 16; i++) q[i] = 8'($urandom);
		return q;
	endfunction

	// mechanism name after the header of an auth request; a key length of 12 covers it, one of 2 does not
	function automatic byte_q_t kv_auth_req();
		byte_q_t q = zeros(24);
		string   m = mech_names[$urandom_range(0, 4)];
		q[0] = KV_REQ_MAGIC;
		q[1] = OP_AUTH;
		q[3] = ($urandom_range(0, 5) == 0) ? 8'd2 : 8'd12;
		q[5] = 8'($urandom_range(0, 3));
		for (int i = 0; i < m.len(); i++) q.push_back(m[i]);
		repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(97, 122)));
		return q;
	endfunction

	function automatic byte_q_t kv_list_rsp();
		byte_q_t q = zeros(24);
		int      body;
		string   m;
		q[0] = KV_RSP_MAGIC;
		q[1] = OP_LIST;
		for (int k = $urandom_range(0, 4); k < 5; k += $urandom_range(1, 3)) begin
			m = mech_names[k];
			for (int i = 0; i < m.len(); i++) q.push_back(m[i]);
			q.push_back(" ");
		end
		body = q.size() - 24;
		case ($urandom_range(0, 5))
			0: body = $urandom_range(0, 4);
			1: body = $urandom;
			default: ;
		endcase
		{q[8], q[9], q[10], q[11]} = body;
		return q;
	endfunction

	function automatic byte_q_t kv_auth_rsp();
		byte_q_t q = zeros(24);
		q[0] = KV_RSP_MAGIC;
		q[1] = OP_AUTH;
		return q;
	endfunction

	function automatic byte_q_t pmap_req(bit use_x);
		byte_q_t q = rand_bytes(use_x ? 12 : $urandom_range(4, 10));
		q[2] = use_x ? "x" : "z";
		if (use_x) begin
			q[5] = node_byte();
			q[6] = 8'd0;
		end
		return q;
	endfunction

	function automatic byte_q_t pmap_rsp(bit use_y);
		byte_q_t q = rand_bytes(use_y ? $urandom_range(4, 8) : 12);
		q[0] = use_y ? "y" : "w";
		if (!use_y) begin
			q[4] = node_byte();
			q[5] = 8'd0;
		end
		return q;
	endfunction

	function automatic byte_q_t dist_msg(logic [7:0] tag);
		byte_q_t q = rand_bytes($urandom_range(5, 16));
		string   st;
		case ($urandom_range(0, 3))
			0: st = "ok";
			1: st = "nok";
			2: st = {"not_", "allowed"};
			default: st = "alive";
		endcase
		{q[0], q[1]} = 16'(q.size() - 2);
		q[2] = tag;
		if (tag == "n") {q[3], q[4]} = 16'($urandom_range(0, 20));
		if (tag == "s" && $urandom_range(0, 3) != 0) begin
			q = q[0:2];
			for (int i = 0; i < st.len(); i++) q.push_back(st[i]);
			{q[0], q[1]} = 16'(q.size() - 2);
		end
		return q;
	endfunction

	// one session: a well-formed or mismatched exchange or random packets, sometimes damaged
	task automatic run_session();
		byte_q_t pkts [$];
		bit      dirs [$];
		byte_q_t p;
		bit      ingress = 1'($urandom_range(0, 1));
		int      k;
		case ($urandom_range(0, 9))
			0: begin pkts = '{kv_list_req(), kv_list_rsp()}; dirs = '{1, 0}; end
			1: begin pkts = '{kv_auth_req(), kv_auth_rsp()}; dirs = '{1, 0}; end
			2: begin pkts = '{kv_list_req(), kv_auth_rsp()}; dirs = '{1, 0}; end
			3: begin pkts = '{pmap_req(0), pmap_rsp(0)}; dirs = '{1, 0}; end
			4: begin pkts = '{pmap_req(1), pmap_rsp(1)}; dirs = '{1, 0}; end
			5: begin
				pkts = '{dist_msg("n"), dist_msg("s"), dist_msg("r"), dist_msg("a"),
					dist_msg("a")};
				dirs = '{1, 0, 1, 0, 1};
			end
			6: begin pkts = '{kv_list_rsp(), kv_list_req()}; dirs = '{0, 1}; end
			7: begin pkts = '{rand_bytes($urandom_range(1, 3)), kv_list_req(),
				kv_list_rsp()}; dirs = '{1, 1, 0}; end
			8: begin pkts = '{pmap_req(0), pmap_rsp(1)}; dirs = '{1, 0}; end
			default: begin pkts = '{rand_bytes($urandom_range(1, 40)),
				rand_bytes($urandom_range(1, 40))}; dirs = '{1, 1'($urandom_range(0, 1))}; end
		endcase
		if ($urandom_range(0, 7) == 0) begin
			k = $urandom_range(0, pkts.size() - 1);
			p = pkts[k];
			p[$urandom_range(0, p.size() - 1)] = 8'($urandom);
			pkts[k] = p;
		end
		if ($urandom_range(0, 5) == 0) begin
			pkts.push_back(rand_bytes($urandom_range(1, 30)));
			dirs.push_back(1'($urandom_range(0, 1)));
		end
		foreach (pkts[i]) begin
			put_packet(pkts[i], dirs[i], i == 0, ingress,
				i > 0 && $urandom_range(0, 15) == 0);
			random_pkts++;
		end
	endtask

	// bytes with every flag at random
	task automatic noise_bytes(int n);
		repeat (n)
			put_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
				1'($urandom_range(0, 1)));
	endtask

	task automatic set_regs(logic [15:0] fr, logic [15:0] ve, logic [15:0] bo);
		write_reg(CFG_FRAME, fr);
		write_reg(CFG_VER, ve);
		write_reg(CFG_BODY, bo);
		cfg_ch.valid <= 0;
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.payload_byte = 0;
		in_ch.from_client = 0;
		in_ch.packet_first = 0;
		in_ch.packet_last = 0;
		in_ch.session_begin = 0;
		in_ch.session_ingress = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CFG_FRAME;
		cfg_ch.data = 0;
		hold_req = 0;
		no_gaps = 0;
		random_pkts = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: byte before any packet start, then key-value, port-mapper, distribution packets
		put_byte(8'hff, 1, 0, 1, 0, 1);
		put_packet('{8'h80, 8'h20}, 1, 1, 0);
		put_packet(kv_list_req(), 1, 1, 1);
		put_packet(kv_list_rsp(), 0, 0, 1);
		put_packet(kv_auth_req(), 1, 1, 0);
		put_packet(kv_auth_rsp(), 0, 0, 0);
		put_packet(kv_auth_rsp(), 0, 0, 0);
		put_packet(pmap_rsp(1), 0, 1, 1);
		put_packet(dist_msg("n"), 1, 1, 0);
		put_packet(dist_msg("s"), 0, 0, 1);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: ;
				1: set_regs(16'd0, 16'd0, 16'd0);
				2: set_regs(16'hffff, 16'hffff, 16'hffff);
				3: set_regs(16'd20, 16'd5, 16'd30);
				default: set_regs(16'($urandom), 16'($urandom_range(0, 20)),
					16'($urandom_range(0, 300)));
			endcase
			no_gaps = (phase == 2);
			if (phase == 1) hold_req = 1;
			while (random_pkts < (phase + 1) * 5) begin
				if ($urandom_range(0, 9) == 0) noise_bytes($urandom_range(1, 20));
				else run_session();
			end
			drain();
		end

		$display("summary: %0d verdicts checked, %0d identified, %0d rejected",
			verdict_count, ident_count, reject_count);
		$display("covered key-value SASL, port-mapper, distribution and noise sessions");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bkc_pkg.sv
hw/rtl/bkc_if.sv
hw/rtl/bkc_capture.sv
hw/rtl/bkc_decide.sv
hw/rtl/binary_kv_sasl_erlang_classifier.sv
test/binary_kv_sasl_erlang_classifier_checker.sv
test/binary_kv_sasl_erlang_classifier_test.sv
